### sv/asbox_pkg.sv
// shared constants and galois-field helpers for the aes substitution byte unit
// no dependencies; used by the interfaces and the top level
package asbox_pkg;

   // field and substitution constants
   localparam logic [8:0] POLY_RESET      = 9'h11B;
   localparam logic [7:0] POLY_LOW_RESET  = POLY_RESET[7:0];
   localparam logic [7:0] FWD_CONST       = 8'h63;
   localparam logic [7:0] INV_CONST       = 8'h05;

   // x^254 is built from 13 dependent field multiplies, one per stage
   localparam int unsigned NUM_MUL_STAGES = 13;

   // substitution direction
   typedef enum logic {
      CMD_FORWARD = 1'b0,
      CMD_INVERSE = 1'b1
   } cmd_type;

   typedef logic [7:0] byte_type;

   // shift-and-add product modulo x^8 + low
   function automatic byte_type gf_mul(input byte_type a, input byte_type b,
                                       input byte_type low);
      byte_type acc;
      byte_type sh;
      acc = '0;
      sh  = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ sh;
         end
         sh = sh[7] ? ({sh[6:0], 1'b0} ^ low) : {sh[6:0], 1'b0};
      end
      return acc;
   endfunction

   // forward affine map: b ^ ror4 ^ ror5 ^ ror6 ^ ror7, then xor 0x63
   function automatic byte_type fwd_affine(input byte_type v);
      return v ^ {v[3:0], v[7:4]} ^ {v[4:0], v[7:5]} ^ {v[5:0], v[7:6]}
               ^ {v[6:0], v[7]} ^ FWD_CONST;
   endfunction

   // inverse affine map: ror2 ^ ror5 ^ ror7, then xor 0x05
   function automatic byte_type inv_affine(input byte_type v);
      return {v[1:0], v[7:2]} ^ {v[4:0], v[7:5]} ^ {v[6:0], v[7]} ^ INV_CONST;
   endfunction

endpackage

### sv/asbox_if.sv
// valid/ready channel interfaces for the request and response items
// depends on asbox_pkg
interface asbox_req_if;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   asbox_pkg::byte_type  data_in;

   modport source (output valid, output cmd, output data_in, input ready);
   modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface asbox_rsp_if;
   logic                 valid;
   logic                 ready;
   asbox_pkg::byte_type  data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

### sv/aes_sbox_forward_inverse_unit.sv
// AES substitution byte unit, forward and inverse, computed without a table.
// One item is accepted per cycle while the output slot is free or being taken,
// and the pipeline holds up to 14 items. An item passes stage registers 0 to
// 13 in order; the depth is set by the chain of 13 field multiplies that
// forms x^254 (x^2, x^3, x^6, x^7, ... x^127, x^254), one multiply per stage.
// A stall on the response side freezes every stage; nothing is dropped or
// repeated. The user must write the field modulus through csr_wr_en/csr_wr_data
// only while the unit is idle; the block does not enforce this. Only its low
// eight bits enter the reduction, bit 8 always taken as set; reset value 0x11B.
// depends on asbox_pkg and asbox_if
module aes_sbox_forward_inverse_unit (
   input  logic                 clock,
   input  logic                 reset,
   asbox_req_if.sink            req_ch,
   asbox_rsp_if.source          rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [8:0]           csr_wr_data
);

   localparam int unsigned LAST = asbox_pkg::NUM_MUL_STAGES;

   // modulus register
   asbox_pkg::byte_type poly_low_ff;

   // pipeline state: stage 0 holds the input, stage LAST the result
   // base copies are kept only up to the last multiply by the base
   logic [LAST:0]       valid_ff;
   logic [LAST:0]       cmd_ff;
   asbox_pkg::byte_type base_ff [0:LAST-2];
   asbox_pkg::byte_type val_ff  [0:LAST];
   asbox_pkg::byte_type val_in  [0:LAST];

   logic advance;

   // whole pipe moves when the output slot is free or being taken
   assign advance      = !valid_ff[LAST] || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign rsp_ch.valid    = valid_ff[LAST];
   assign rsp_ch.data_out = val_ff[LAST];

   // modulus write
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_low_ff <= asbox_pkg::POLY_LOW_RESET;
      end else if (csr_wr_en) begin
         poly_low_ff <= csr_wr_data[7:0];
      end
   end

   // stage 0: inverse affine on entry for inverse items
   assign val_in[0] = (req_ch.cmd == asbox_pkg::CMD_INVERSE) ?
                      asbox_pkg::inv_affine(req_ch.data_in) : req_ch.data_in;

   // multiply stages: odd stages square, even stages multiply by the base
   for (genvar g = 1; g <= LAST; g++) begin : g_mul
      asbox_pkg::byte_type prod;
      if (g % 2 == 1) begin : g_sq
         assign prod = asbox_pkg::gf_mul(val_ff[g-1], val_ff[g-1], poly_low_ff);
      end else begin : g_mb
         assign prod = asbox_pkg::gf_mul(val_ff[g-1], base_ff[g-1], poly_low_ff);
      end
      if (g == LAST) begin : g_out
         // forward items leave through the forward affine map
         assign val_in[g] = (cmd_ff[g-1] == asbox_pkg::CMD_INVERSE) ?
                            prod : asbox_pkg::fwd_affine(prod);
      end else begin : g_mid
         assign val_in[g] = prod;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAST-1:0], req_ch.valid};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff     <= {cmd_ff[LAST-1:0], req_ch.cmd};
         val_ff[0]  <= val_in[0];
         base_ff[0] <= val_in[0];
         for (int k = 1; k <= LAST; k++) begin
            val_ff[k] <= val_in[k];
         end
         for (int k = 1; k <= LAST - 2; k++) begin
            base_ff[k] <= base_ff[k-1];
         end
      end
   end

   // a valid item in stage 0 moves on to stage 1 when the pipe advances
   a_valid_travels: assert property (@(posedge clock) disable iff (reset)
      advance && valid_ff[0] |=> valid_ff[1])
      else $error("stage 0 item lost on advance");

   // a stall freezes every valid bit
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved during a stall");

   // a zero entering the last multiply yields 0 or 0x63
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      advance && valid_ff[LAST-1] && (val_ff[LAST-1] == '0) |=>
         (rsp_ch.data_out == ((cmd_ff[LAST] == asbox_pkg::CMD_INVERSE) ?
                              8'h00 : asbox_pkg::FWD_CONST)))
      else $error("zero byte substituted wrongly");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

endmodule

### dv/tb_aes_sbox_forward_inverse_unit.sv
// testbench for aes_sbox_forward_inverse_unit: random and directed substitution items
// checked against a local gf(2^8) predictor over several modulus settings and idling mixes
// depends on asbox_pkg, asbox_if and the unit itself
module tb_aes_sbox_forward_inverse_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HOLD_CYCLES    = 90;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned FLUSH_CYCLES   = 24;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct {
      asbox_pkg::cmd_type  op;
      asbox_pkg::byte_type value;
   } sub_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic [8:0] csr_wr_data;

   asbox_req_if req_bus ();
   asbox_rsp_if rsp_bus ();

   // items waiting to be offered and substituted bytes still owed by the unit
   sub_item_type        pend_q[$];
   asbox_pkg::byte_type sbox_expected_q[$];

   // low byte of the field modulus as last written
   asbox_pkg::byte_type modulus_low;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_ask       = 0;
   int unsigned hold_seen;
   int unsigned hold_left;
   int unsigned result_count;
   int unsigned fault_count;
   int unsigned quiet_cycles;

   aes_sbox_forward_inverse_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // product modulo x^8 + low, msb first
   function automatic asbox_pkg::byte_type field_product(input asbox_pkg::byte_type a,
                                                         input asbox_pkg::byte_type b,
                                                         input asbox_pkg::byte_type low);
      asbox_pkg::byte_type acc;
      acc = '0;
      for (int i = 7; i >= 0; i--) begin
         acc = acc[7] ? ({acc[6:0], 1'b0} ^ low) : {acc[6:0], 1'b0};
         if (b[i]) begin
            acc = acc ^ a;
         end
      end
      return acc;
   endfunction

   // x^254 by square and multiply, zero stays zero
   function automatic asbox_pkg::byte_type field_inverse(input asbox_pkg::byte_type x,
                                                         input asbox_pkg::byte_type low);
      asbox_pkg::byte_type acc;
      asbox_pkg::byte_type base;
      int unsigned         e;
      acc  = 8'h01;
      base = x;
      e    = 254;
      while (e != 0) begin
         if (e[0]) begin
            acc = field_product(acc, base, low);
         end
         base = field_product(base, base, low);
         e    = e >> 1;
      end
      return acc;
   endfunction

   // substituted byte for one item
   function automatic asbox_pkg::byte_type sbox_predict(input asbox_pkg::cmd_type op,
                                                        input asbox_pkg::byte_type value,
                                                        input asbox_pkg::byte_type low);
      asbox_pkg::byte_type v;
      asbox_pkg::byte_type r;
      r = '0;
      if (op == asbox_pkg::CMD_FORWARD) begin
         v = field_inverse(value, low);
         for (int i = 0; i < 8; i++) begin
            r[i] = v[i] ^ v[(i + 4) % 8] ^ v[(i + 5) % 8] ^ v[(i + 6) % 8]
                 ^ v[(i + 7) % 8];
         end
         return r ^ asbox_pkg::FWD_CONST;
      end
      for (int i = 0; i < 8; i++) begin
         r[i] = value[(i + 2) % 8] ^ value[(i + 5) % 8] ^ value[(i + 7) % 8];
      end
      return field_inverse(r ^ asbox_pkg::INV_CONST, low);
   endfunction

   // driver: offer the next pending item when the slot is free
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid   <= 1'b1;
            req_bus.cmd     <= pend_q[0].op;
            req_bus.data_in <= pend_q[0].value;
            pend_q.delete(0);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: check results, record accepted items, drive ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         modulus_low   <= asbox_pkg::POLY_LOW_RESET;
         hold_seen     <= 0;
         hold_left     <= 0;
         result_count  <= 0;
         fault_count   <= 0;
      end else begin
         // result side first so an item accepted now cannot satisfy it
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count <= result_count + 1;
            if (sbox_expected_q.size() == 0) begin
               if (fault_count < MAX_REPORTS) begin
                  $display("unexpected result 0x%02h with no item outstanding",
                           rsp_bus.data_out);
               end
               fault_count <= fault_count + 1;
            end else begin
               if (rsp_bus.data_out !== sbox_expected_q[0]) begin
                  if (fault_count < MAX_REPORTS) begin
                     $display("result %0d data_out: expected 0x%02h, got 0x%02h",
                              result_count, sbox_expected_q[0], rsp_bus.data_out);
                  end
                  fault_count <= fault_count + 1;
               end
               sbox_expected_q.delete(0);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            sbox_expected_q.push_back(
               sbox_predict(asbox_pkg::cmd_type'(req_bus.cmd), req_bus.data_in,
                            modulus_low));
         end
         if (csr_wr_en) begin
            modulus_low <= csr_wr_data[7:0];
         end
         // long hold-off on request, otherwise random stalls
         if (hold_ask != hold_seen) begin
            hold_seen     <= hold_ask;
            hold_left     <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no handshake and no register write
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", quiet_cycles);
         $display("** aes_sbox_forward_inverse_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_modulus(input logic [8:0] poly);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= poly;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pend_q.size() != 0 || req_bus.valid || sbox_expected_q.size() != 0);
   endtask

   // one setting of the modulus and idling mix, directed or random items
   task automatic run_phase(input logic [8:0] poly, input int unsigned snd_pct,
                            input int unsigned rcv_pct, input int unsigned count,
                            input bit directed, input bit long_hold);
      asbox_pkg::byte_type corner_bytes[12];
      sub_item_type        item;
      corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h02, 8'h7F,
                       8'h53, 8'hCA, 8'h63, 8'h7C, 8'hAA, 8'h55};
      write_modulus(poly);
      @(negedge clock);
      send_idle_pct  = snd_pct;
      recv_stall_pct = rcv_pct;
      if (long_hold) begin
         hold_ask++;
      end
      if (directed) begin
         // zero byte, all ones, single bits, a known inverse pair, the byte whose
         // inverse affine map is zero, alternating bits; both directions
         foreach (corner_bytes[i]) begin
            item.op    = asbox_pkg::CMD_FORWARD;
            item.value = corner_bytes[i];
            pend_q.push_back(item);
            item.op    = asbox_pkg::CMD_INVERSE;
            pend_q.push_back(item);
         end
      end else begin
         for (int unsigned n = 0; n < count; n++) begin
            item.op    = ($urandom_range(1) != 0) ? asbox_pkg::CMD_INVERSE
                                                  : asbox_pkg::CMD_FORWARD;
            item.value = asbox_pkg::byte_type'($urandom_range(255));
            pend_q.push_back(item);
         end
      end
      wait_drained();
   endtask

   // stimulus and verdict
   initial begin
      req_bus.valid   = 1'b0;
      req_bus.cmd     = asbox_pkg::CMD_FORWARD;
      req_bus.data_in = '0;
      rsp_bus.ready   = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_phase(asbox_pkg::POLY_RESET, 0, 0, 0, 1'b1, 1'b0);
      run_phase(asbox_pkg::POLY_RESET, 61, 0, 300, 1'b0, 1'b0);
      run_phase(9'h11D, 0, 61, 250, 1'b0, 1'b1);
      // reducible extremes, then a modulus with bit 8 clear
      run_phase(9'h100, 8, 8, 150, 1'b0, 1'b0);
      run_phase(9'h1FF, 0, 0, 150, 1'b0, 1'b0);
      run_phase(9'h01B, 61, 0, 100, 1'b0, 1'b0);
      run_phase(9'($urandom_range(511, 256)), 8, 8, 200, 1'b0, 1'b1);
      run_phase(asbox_pkg::POLY_RESET, 0, 61, 200, 1'b0, 1'b0);

      repeat (FLUSH_CYCLES) @(negedge clock);
      if (fault_count == 0 && sbox_expected_q.size() == 0) begin
         $display("** aes_sbox_forward_inverse_unit: PASSED **");
      end else begin
         $display("** aes_sbox_forward_inverse_unit: FAILED **");
      end
      $finish;
   end

endmodule
